/* sv/segment_intersection_macros.svh */
// ----------------------------------------------------------------------------
// segment_intersection_macros.svh
// Assertion shorthands shared by the segment intersection RTL. Defining
// NO_ASSERTIONS turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_INTERSECTION_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, ignored while reset is high
`define SI_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("segment_intersection: assertion failed");

// next-cycle implication, ignored while reset is high
`define SI_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("segment_intersection: assertion failed");

`else

`define SI_ASSERT_IMP(label, clk, rst, ante, cons)
`define SI_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

/* sv/segint_pkg.sv */
// ----------------------------------------------------------------------------
// segint_pkg
// Shared widths, defaults, saturation limits and the control struct that
// travels down the divider chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package segint_pkg;

  localparam int FIELD_W        = 16;  // coordinate field width
  localparam int OUT_W          = 24;  // crossing point field width
  localparam int FRAC_MAX       = 16;  // fraction bits act as at most this
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int CW_DEF         = 16;  // effective coordinate width
  localparam int QB_DEF         = 24;  // quotient bits = CW + fraction bits

  // largest positive point, and most negative point (also 2^23 unsigned)
  localparam logic [OUT_W-1:0] SAT_POS = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_NEG = {1'b1, {(OUT_W-1){1'b0}}};

  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;  // sign of x quotient
    logic neg_y;  // sign of y quotient
  } segint_ctl_t;

endpackage

/* sv/segment_intersection.sv */
// ----------------------------------------------------------------------------
// segment_intersection
// Exact 2-D segment intersection test with a fixed-point crossing point.
//
// Input channel pair_valid/pair_ready: one beat carries both segments,
// A = a_start..a_end and B = b_start..b_end, as signed coordinates.
// Output channel res_valid/res_ready: one beat per input beat, in order,
// with hit and the crossing point (FRAC_BITS fraction bits, truncated
// toward zero, saturated to 24 bits). Parallel or collinear pairs and
// misses give hit = 0 and a zero point.
// Throughput: one beat per cycle while the skid entry is empty. Seven front
// stages form the cross products, then a chain of CW + FW division cells
// yields one quotient bit each for both coordinates, then the output
// register, where CW and FW are COORD_BITS and FRAC_BITS capped at 16.
// Reset clears every valid bit; pair_ready is high once reset is released.
// When the receiver stalls, one further result lands in a skid entry and
// the whole pipeline then holds; pair_ready comes from that register only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_intersection import segint_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pair_valid,
  output logic                      pair_ready,
  input  logic signed [FIELD_W-1:0] a_start_x,
  input  logic signed [FIELD_W-1:0] a_start_y,
  input  logic signed [FIELD_W-1:0] a_end_x,
  input  logic signed [FIELD_W-1:0] a_end_y,
  input  logic signed [FIELD_W-1:0] b_start_x,
  input  logic signed [FIELD_W-1:0] b_start_y,
  input  logic signed [FIELD_W-1:0] b_end_x,
  input  logic signed [FIELD_W-1:0] b_end_y,
  output logic                      res_valid,
  input  logic                      res_ready,
  output logic                      hit,
  output logic signed [OUT_W-1:0]   cross_x,
  output logic signed [OUT_W-1:0]   cross_y
);

  // coordinates wider than the fields act as the field width
  localparam int CW = (COORD_BITS > FIELD_W) ? FIELD_W : COORD_BITS;
  localparam int FW = (FRAC_BITS > FRAC_MAX) ? FRAC_MAX : FRAC_BITS;
  localparam int VW = 2*CW + 1;  // |den| and remainders
  localparam int QB = CW + FW;   // quotient bits = number of cells

  logic adv;  // whole pipeline moves when the skid entry is free

  // chain taps: index 0 from the front end, index k+1 from cell k
  segint_ctl_t   ctl_c   [QB+1];
  logic [VW-1:0] div_c   [QB+1];
  logic [VW-1:0] rem_x_c [QB+1];
  logic [VW-1:0] rem_y_c [QB+1];
  logic [CW-1:0] dvd_x_c [QB+1];
  logic [CW-1:0] dvd_y_c [QB+1];
  logic [QB-1:0] quo_x_c [QB+1];
  logic [QB-1:0] quo_y_c [QB+1];

  assign pair_ready = adv;

  // every quotient bit is shifted in by the chain
  assign quo_x_c[0] = '0;
  assign quo_y_c[0] = '0;

  segint_front #(
    .CW (CW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .adv        (adv),
    .pair_valid (pair_valid),
    .a_start_x  (a_start_x),
    .a_start_y  (a_start_y),
    .a_end_x    (a_end_x),
    .a_end_y    (a_end_y),
    .b_start_x  (b_start_x),
    .b_start_y  (b_start_y),
    .b_end_x    (b_end_x),
    .b_end_y    (b_end_y),
    .ctl        (ctl_c[0]),
    .divisor    (div_c[0]),
    .rem_x      (rem_x_c[0]),
    .rem_y      (rem_y_c[0]),
    .dvd_x      (dvd_x_c[0]),
    .dvd_y      (dvd_y_c[0])
  );

  // one cell per quotient bit, MSB first
  for (genvar k = 0; k < QB; k++) begin : g_cell
    segint_cell #(
      .CW (CW),
      .QB (QB)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .adv          (adv),
      .prev_ctl     (ctl_c[k]),
      .prev_divisor (div_c[k]),
      .prev_rem_x   (rem_x_c[k]),
      .prev_rem_y   (rem_y_c[k]),
      .prev_dvd_x   (dvd_x_c[k]),
      .prev_dvd_y   (dvd_y_c[k]),
      .prev_quo_x   (quo_x_c[k]),
      .prev_quo_y   (quo_y_c[k]),
      .ctl          (ctl_c[k+1]),
      .divisor      (div_c[k+1]),
      .rem_x        (rem_x_c[k+1]),
      .rem_y        (rem_y_c[k+1]),
      .dvd_x        (dvd_x_c[k+1]),
      .dvd_y        (dvd_y_c[k+1]),
      .quo_x        (quo_x_c[k+1]),
      .quo_y        (quo_y_c[k+1])
    );
  end

  segint_out #(
    .QB (QB)
  ) u_out (
    .clk       (clk),
    .rst       (rst),
    .last_ctl  (ctl_c[QB]),
    .quo_x     (quo_x_c[QB]),
    .quo_y     (quo_y_c[QB]),
    .adv       (adv),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .hit       (hit),
    .cross_x   (cross_x),
    .cross_y   (cross_y)
  );

endmodule

/* sv/segint_front.sv */
// ----------------------------------------------------------------------------
// segint_front
// Seven-stage front end: deltas, cross products, hit test, scaled point
// numerators and their magnitudes, set up for the divider chain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segint_front import segint_pkg::*; #(
  parameter int CW = CW_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      adv,
  input  logic                      pair_valid,
  input  logic signed [FIELD_W-1:0] a_start_x,
  input  logic signed [FIELD_W-1:0] a_start_y,
  input  logic signed [FIELD_W-1:0] a_end_x,
  input  logic signed [FIELD_W-1:0] a_end_y,
  input  logic signed [FIELD_W-1:0] b_start_x,
  input  logic signed [FIELD_W-1:0] b_start_y,
  input  logic signed [FIELD_W-1:0] b_end_x,
  input  logic signed [FIELD_W-1:0] b_end_y,
  output segint_ctl_t               ctl,
  output logic [2*CW:0]             divisor,
  output logic [2*CW:0]             rem_x,
  output logic [2*CW:0]             rem_y,
  output logic [CW-1:0]             dvd_x,
  output logic [CW-1:0]             dvd_y
);

  localparam int DW  = 2*CW + 2;  // den / snum / tnum
  localparam int VW  = 2*CW + 1;  // |den|, remainder
  localparam int H   = CW + 1;    // split point of den and tnum
  localparam int PPW = 2*CW + 3;  // partial products
  localparam int NW  = 3*CW + 3;  // point numerator

  // coordinates taken at the effective width
  logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  assign ax0 = a_start_x[CW-1:0];
  assign ay0 = a_start_y[CW-1:0];
  assign ax1 = a_end_x[CW-1:0];
  assign ay1 = a_end_y[CW-1:0];
  assign bx0 = b_start_x[CW-1:0];
  assign by0 = b_start_y[CW-1:0];
  assign bx1 = b_end_x[CW-1:0];
  assign by1 = b_end_y[CW-1:0];

  logic v1, v2, v3, v4, v5, v6, valid;

  // stage 1
  logic signed [CW:0]   dax1, day1, dbx1, dby1, wx1, wy1;
  logic signed [CW-1:0] ax0_1, ay0_1;
  // stage 2
  logic signed [DW-1:0] p_den_a, p_den_b, p_s_a, p_s_b, p_t_a, p_t_b;
  logic signed [CW:0]   dax2, day2;
  logic signed [CW-1:0] ax0_2, ay0_2;
  // stage 3
  logic signed [DW-1:0] den3, snum3, tnum3;
  logic signed [CW:0]   dax3, day3;
  logic signed [CW-1:0] ax0_3, ay0_3;
  // stage 4
  logic signed [PPW-1:0] sx_lo4, sx_hi4, sy_lo4, sy_hi4;
  logic signed [PPW-1:0] tx_lo4, tx_hi4, ty_lo4, ty_hi4;
  logic                  hit4, den_neg4;
  logic [VW-1:0]         den_mag4;
  // stage 5
  logic signed [NW-1:0]  sx5, sy5, tx5, ty5;
  logic                  hit5, den_neg5;
  logic [VW-1:0]         den_mag5;
  // stage 6
  logic signed [NW-1:0]  nx6, ny6;
  logic                  hit6, den_neg6;
  logic [VW-1:0]         den_mag6;
  // stage 7 payload
  logic                  hit, neg_x, neg_y;

  // stage 4 combinational
  logic signed [CW+1:0] den_lo, tnum_lo;
  logic signed [CW:0]   den_hi, tnum_hi;
  logic signed [DW-1:0] den_inv;
  logic                 s_ok, t_ok;

  assign den_lo  = {1'b0, den3[H-1:0]};
  assign den_hi  = den3[DW-1:H];
  assign tnum_lo = {1'b0, tnum3[H-1:0]};
  assign tnum_hi = tnum3[DW-1:H];
  assign den_inv = -den3;

  // 0 <= num/den <= 1, tested on signs and magnitudes
  always_comb begin
    if (den3[DW-1]) begin
      s_ok = (snum3[DW-1] || snum3 == '0) && (snum3 >= den3);
      t_ok = (tnum3[DW-1] || tnum3 == '0) && (tnum3 >= den3);
    end else begin
      s_ok = !snum3[DW-1] && (snum3 <= den3);
      t_ok = !tnum3[DW-1] && (tnum3 <= den3);
    end
  end

  // stage 7 combinational: magnitudes
  logic signed [NW-1:0] nx_inv, ny_inv;
  logic [NW-1:0]        mag_x, mag_y;
  assign nx_inv = -nx6;
  assign ny_inv = -ny6;
  assign mag_x  = nx6[NW-1] ? nx_inv : nx6;
  assign mag_y  = ny6[NW-1] ? ny_inv : ny6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      v2    <= 1'b0;
      v3    <= 1'b0;
      v4    <= 1'b0;
      v5    <= 1'b0;
      v6    <= 1'b0;
      valid <= 1'b0;
    end else if (adv) begin
      v1    <= pair_valid;
      v2    <= v1;
      v3    <= v2;
      v4    <= v3;
      v5    <= v4;
      v6    <= v5;
      valid <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // 1: direction vectors and start offset
      dax1  <= (CW+1)'(ax1) - (CW+1)'(ax0);
      day1  <= (CW+1)'(ay1) - (CW+1)'(ay0);
      dbx1  <= (CW+1)'(bx1) - (CW+1)'(bx0);
      dby1  <= (CW+1)'(by1) - (CW+1)'(by0);
      wx1   <= (CW+1)'(ax0) - (CW+1)'(bx0);
      wy1   <= (CW+1)'(ay0) - (CW+1)'(by0);
      ax0_1 <= ax0;
      ay0_1 <= ay0;
      // 2: cross product terms
      p_den_a <= DW'(dax1) * DW'(dby1);
      p_den_b <= DW'(day1) * DW'(dbx1);
      p_s_a   <= DW'(dax1) * DW'(wy1);
      p_s_b   <= DW'(day1) * DW'(wx1);
      p_t_a   <= DW'(dbx1) * DW'(wy1);
      p_t_b   <= DW'(dby1) * DW'(wx1);
      dax2    <= dax1;
      day2    <= day1;
      ax0_2   <= ax0_1;
      ay0_2   <= ay0_1;
      // 3: denominator and numerators
      den3  <= p_den_a - p_den_b;
      snum3 <= p_s_a - p_s_b;
      tnum3 <= p_t_a - p_t_b;
      dax3  <= dax2;
      day3  <= day2;
      ax0_3 <= ax0_2;
      ay0_3 <= ay0_2;
      // 4: hit, |den|, split partial products of start*den + tnum*d
      hit4     <= (den3 != '0) && s_ok && t_ok;
      den_neg4 <= den3[DW-1];
      den_mag4 <= den3[DW-1] ? den_inv[VW-1:0] : den3[VW-1:0];
      sx_lo4   <= PPW'(ax0_3) * PPW'(den_lo);
      sx_hi4   <= PPW'(ax0_3) * PPW'(den_hi);
      sy_lo4   <= PPW'(ay0_3) * PPW'(den_lo);
      sy_hi4   <= PPW'(ay0_3) * PPW'(den_hi);
      tx_lo4   <= PPW'(dax3) * PPW'(tnum_lo);
      tx_hi4   <= PPW'(dax3) * PPW'(tnum_hi);
      ty_lo4   <= PPW'(day3) * PPW'(tnum_lo);
      ty_hi4   <= PPW'(day3) * PPW'(tnum_hi);
      // 5: recombine halves
      sx5      <= (NW'(sx_hi4) <<< H) + NW'(sx_lo4);
      sy5      <= (NW'(sy_hi4) <<< H) + NW'(sy_lo4);
      tx5      <= (NW'(tx_hi4) <<< H) + NW'(tx_lo4);
      ty5      <= (NW'(ty_hi4) <<< H) + NW'(ty_lo4);
      hit5     <= hit4;
      den_neg5 <= den_neg4;
      den_mag5 <= den_mag4;
      // 6: point numerators
      nx6      <= sx5 + tx5;
      ny6      <= sy5 + ty5;
      hit6     <= hit5;
      den_neg6 <= den_neg5;
      den_mag6 <= den_mag5;
      // 7: divider setup; |n| >> CW is below |den| on a hit
      hit     <= hit6;
      neg_x   <= nx6[NW-1] ^ den_neg6;
      neg_y   <= ny6[NW-1] ^ den_neg6;
      divisor <= den_mag6;
      rem_x   <= mag_x[CW +: VW];
      rem_y   <= mag_y[CW +: VW];
      dvd_x   <= mag_x[CW-1:0];
      dvd_y   <= mag_y[CW-1:0];
    end
  end

  assign ctl = {valid, hit, neg_x, neg_y};

endmodule

/* sv/segint_cell.sv */
// ----------------------------------------------------------------------------
// segint_cell
// One restoring division step for both coordinates: shifts in the next
// dividend bit, subtracts |den| when it fits, appends a quotient bit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_intersection_macros.svh"

module segint_cell import segint_pkg::*; #(
  parameter int CW = CW_DEF,
  parameter int QB = QB_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  segint_ctl_t   prev_ctl,
  input  logic [2*CW:0] prev_divisor,
  input  logic [2*CW:0] prev_rem_x,
  input  logic [2*CW:0] prev_rem_y,
  input  logic [CW-1:0] prev_dvd_x,
  input  logic [CW-1:0] prev_dvd_y,
  input  logic [QB-1:0] prev_quo_x,
  input  logic [QB-1:0] prev_quo_y,
  output segint_ctl_t   ctl,
  output logic [2*CW:0] divisor,
  output logic [2*CW:0] rem_x,
  output logic [2*CW:0] rem_y,
  output logic [CW-1:0] dvd_x,
  output logic [CW-1:0] dvd_y,
  output logic [QB-1:0] quo_x,
  output logic [QB-1:0] quo_y
);

  localparam int VW = 2*CW + 1;

  logic            valid, hit, neg_x, neg_y;
  logic [VW+1:0]   trial_x, trial_y;
  logic [VW-1:0]   rem_x_next, rem_y_next;

  always_comb begin
    trial_x = {1'b0, prev_rem_x, prev_dvd_x[CW-1]} - {2'b00, prev_divisor};
    trial_y = {1'b0, prev_rem_y, prev_dvd_y[CW-1]} - {2'b00, prev_divisor};
    if (trial_x[VW+1]) begin
      rem_x_next = {prev_rem_x[VW-2:0], prev_dvd_x[CW-1]};
    end else begin
      rem_x_next = trial_x[VW-1:0];
    end
    if (trial_y[VW+1]) begin
      rem_y_next = {prev_rem_y[VW-2:0], prev_dvd_y[CW-1]};
    end else begin
      rem_y_next = trial_y[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (adv) begin
      valid <= prev_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit     <= prev_ctl.hit;
      neg_x   <= prev_ctl.neg_x;
      neg_y   <= prev_ctl.neg_y;
      divisor <= prev_divisor;
      rem_x   <= rem_x_next;
      rem_y   <= rem_y_next;
      dvd_x   <= {prev_dvd_x[CW-2:0], 1'b0};
      dvd_y   <= {prev_dvd_y[CW-2:0], 1'b0};
      quo_x   <= {prev_quo_x[QB-2:0], ~trial_x[VW+1]};
      quo_y   <= {prev_quo_y[QB-2:0], ~trial_y[VW+1]};
    end
  end

  assign ctl = {valid, hit, neg_x, neg_y};

  // on a hit the partial remainder always stays below |den|
  `SI_ASSERT_IMP(a_rem_x_bound, clk, rst, valid && hit, rem_x < divisor)
  `SI_ASSERT_IMP(a_rem_y_bound, clk, rst, valid && hit, rem_y < divisor)

endmodule

/* sv/segint_out.sv */
// ----------------------------------------------------------------------------
// segint_out
// Applies the quotient sign, saturates to the point width, zeroes misses,
// and holds the result in an output register backed by one skid entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "segment_intersection_macros.svh"

module segint_out import segint_pkg::*; #(
  parameter int QB = QB_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  segint_ctl_t             last_ctl,
  input  logic [QB-1:0]           quo_x,
  input  logic [QB-1:0]           quo_y,
  output logic                    adv,
  output logic                    res_valid,
  input  logic                    res_ready,
  output logic                    hit,
  output logic signed [OUT_W-1:0] cross_x,
  output logic signed [OUT_W-1:0] cross_y
);

  localparam int SW = (QB > OUT_W) ? QB : OUT_W;

  // sign and magnitude to saturated two's complement
  function automatic logic [OUT_W-1:0] sat_point(input logic [QB-1:0] mag,
                                                 input logic          neg);
    logic [SW-1:0] mag_e;
    logic [SW-1:0] inv;
    logic [OUT_W-1:0] res;
    mag_e = SW'(mag);
    inv   = -mag_e;
    if (neg) begin
      res = (mag_e > SW'(SAT_NEG)) ? SAT_NEG : inv[OUT_W-1:0];
    end else begin
      res = (mag_e > SW'(SAT_POS)) ? SAT_POS : mag_e[OUT_W-1:0];
    end
    return res;
  endfunction

  logic                    skid_valid;
  logic                    skid_hit;
  logic signed [OUT_W-1:0] skid_x, skid_y;
  logic signed [OUT_W-1:0] x_next, y_next;

  always_comb begin
    if (last_ctl.hit) begin
      x_next = sat_point(quo_x, last_ctl.neg_x);
      y_next = sat_point(quo_y, last_ctl.neg_y);
    end else begin
      x_next = '0;
      y_next = '0;
    end
  end

  assign adv = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || res_ready) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        res_valid  <= last_ctl.valid;
      end
    end else if (last_ctl.valid && !skid_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!res_valid || res_ready) begin
      if (skid_valid) begin
        hit     <= skid_hit;
        cross_x <= skid_x;
        cross_y <= skid_y;
      end else begin
        hit     <= last_ctl.hit;
        cross_x <= x_next;
        cross_y <= y_next;
      end
    end else if (!skid_valid) begin
      skid_hit <= last_ctl.hit;
      skid_x   <= x_next;
      skid_y   <= y_next;
    end
  end

  `SI_ASSERT_IMP(a_skid_behind_out, clk, rst, skid_valid, res_valid)
  `SI_ASSERT_IMP(a_miss_is_zero, clk, rst, res_valid && !hit, cross_x == '0 && cross_y == '0)
  `SI_ASSERT_NXT(a_skid_kept, clk, rst, skid_valid && !res_ready, skid_valid && res_valid)

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for segment_intersection. Each beat on the pair
// channel carries two segments. A software model of the exact crossing test
// works out the hit flag and the fixed-point point for each random beat and
// each untyped table row, and a queue holds all expected results until the
// block returns them in order. The bench runs a short directed table, then
// about 1900 random pairs across four handshake patterns.
// ----------------------------------------------------------------------------

module tb_top;
  import segint_pkg::*;

  // pipeline depth given for the default widths: 7 front stages,
  // CW + FW divider cells
  localparam int PIPE_LAT       = 7 + CW_DEF + FRAC_BITS_DEF;
  localparam int DRAIN_CYCLES   = 2 * PIPE_LAT;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_DIRECTED   = 16;
  localparam int NUM_RANDOM     = 1880;
  localparam int BLOCK_LEN      = 235;  // random beats before the handshake pattern changes
  localparam int MAX_REPORTS    = 10;

  localparam longint PT_MAX = (longint'(1) <<< (OUT_W - 1)) - 1;
  localparam longint PT_MIN = -(longint'(1) <<< (OUT_W - 1));
  localparam longint FRAC_ONE = longint'(1) <<< FRAC_BITS_DEF;

  typedef logic signed [FIELD_W-1:0] coord_t;
  typedef logic signed [OUT_W-1:0]   point_t;

  typedef struct {
    coord_t ax0, ay0, ax1, ay1;  // segment A start, end
    coord_t bx0, by0, bx1, by1;  // segment B start, end
  } pair_t;

  typedef struct {
    logic   hit;
    point_t px;
    point_t py;
  } crossing_t;

  typedef struct {
    pair_t     seg;
    bit        typed;  // 1: use the result written in the row
    crossing_t want;
  } row_t;

  // handshake patterns: idle / stall percentages per phase
  typedef enum int {
    PH_STREAM   = 0,
    PH_SRC_IDLE = 1,
    PH_SNK_STALL = 2,
    PH_BOTH     = 3
  } hs_phase_e;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic   pair_valid = 1'b0;
  logic   pair_ready;
  pair_t  cur_pair = '{default: '0};
  logic   res_valid;
  logic   res_ready = 1'b0;
  logic   hit;
  point_t cross_x;
  point_t cross_y;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  crossing_t pending_crossings[$];
  int        pairs_sent = 0;
  int        hits_seen = 0;
  int        misses_seen = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  segment_intersection #(
    .COORD_BITS(COORD_BITS_DEF),
    .FRAC_BITS (FRAC_BITS_DEF)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .pair_valid(pair_valid),
    .pair_ready(pair_ready),
    .a_start_x (cur_pair.ax0),
    .a_start_y (cur_pair.ay0),
    .a_end_x   (cur_pair.ax1),
    .a_end_y   (cur_pair.ay1),
    .b_start_x (cur_pair.bx0),
    .b_start_y (cur_pair.by0),
    .b_end_x   (cur_pair.bx1),
    .b_end_y   (cur_pair.by1),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .hit       (hit),
    .cross_x   (cross_x),
    .cross_y   (cross_y)
  );

  // --------------------------------------------------------------------------
  // Crossing model, all in 64-bit so the cross products never wrap
  // --------------------------------------------------------------------------

  // 0 <= num/den <= 1 without dividing; den is nonzero
  function automatic bit param_in_unit(longint num, longint den);
    if (den > 0) begin
      return num >= 0 && num <= den;
    end
    return num <= 0 && num >= den;
  endfunction

  // trunc((start + tnum*d/den) * 2^F) as one exact quotient, then clamp
  function automatic longint crossing_coord(longint start, longint d, longint tnum,
                                            longint den);
    longint n, q, rm, frac, v;
    n    = start * den + tnum * d;
    q    = n / den;
    rm   = n % den;
    frac = (rm * FRAC_ONE) / den;
    if (q > (PT_MAX >>> FRAC_BITS_DEF) + 1) begin
      return PT_MAX;
    end
    if (q < (PT_MIN >>> FRAC_BITS_DEF) - 1) begin
      return PT_MIN;
    end
    v = q * FRAC_ONE + frac;
    if (v > PT_MAX) begin
      return PT_MAX;
    end
    if (v < PT_MIN) begin
      return PT_MIN;
    end
    return v;
  endfunction

  function automatic crossing_t predict_crossing(pair_t p);
    longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    longint dax, day, dbx, dby, wx, wy, den, snum, tnum;
    crossing_t r;
    ax0 = p.ax0;  ay0 = p.ay0;  ax1 = p.ax1;  ay1 = p.ay1;
    bx0 = p.bx0;  by0 = p.by0;  bx1 = p.bx1;  by1 = p.by1;
    dax = ax1 - ax0;  day = ay1 - ay0;
    dbx = bx1 - bx0;  dby = by1 - by0;
    wx  = ax0 - bx0;  wy  = ay0 - by0;
    den  = dax * dby - day * dbx;
    snum = dax * wy - day * wx;   // position along B
    tnum = dbx * wy - dby * wx;   // position along A
    r = '{hit: 1'b0, px: '0, py: '0};
    // parallel and collinear pairs (den == 0) never hit, overlap or not
    if (den != 0 && param_in_unit(snum, den) && param_in_unit(tnum, den)) begin
      r.hit = 1'b1;
      r.px  = point_t'(crossing_coord(ax0, dax, tnum, den));
      r.py  = point_t'(crossing_coord(ay0, day, tnum, den));
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Directed table. Rows with typed = 1 carry the result worked out by hand.
  // --------------------------------------------------------------------------
  row_t dir_rows [NUM_DIRECTED] = '{
    // plus sign through the origin
    '{'{-16'sd10, 16'sd0, 16'sd10, 16'sd0, 16'sd0, -16'sd10, 16'sd0, 16'sd10},
      1'b1, '{1'b1, 24'sd0, 24'sd0}},
    // parallel, offset by 5
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd0, 16'sd5, 16'sd10, 16'sd5},
      1'b1, '{1'b0, 24'sd0, 24'sd0}},
    // collinear and overlapping: still a miss
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd5, 16'sd0, 16'sd15, 16'sd0},
      1'b1, '{1'b0, 24'sd0, 24'sd0}},
    // both segments collapsed to the origin
    '{'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
      1'b1, '{1'b0, 24'sd0, 24'sd0}},
    // B starts on the end of A: t = 1, s = 0, point (10, 0)
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd10, 16'sd0, 16'sd10, 16'sd10},
      1'b1, '{1'b1, 24'sd2560, 24'sd0}},
    // one unit past the end of A
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd0, 16'sd11, 16'sd0, 16'sd11, 16'sd10},
      1'b1, '{1'b0, 24'sd0, 24'sd0}},
    // full-range diagonals meet at (-0.5, -0.5)
    '{'{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
        16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000},
      1'b1, '{1'b1, -24'sd128, -24'sd128}},
    // every coordinate at the positive extreme
    '{'{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
        16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff},
      1'b1, '{1'b0, 24'sd0, 24'sd0}},
    // every coordinate at the negative extreme
    '{'{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
        16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000},
      1'b1, '{1'b0, 24'sd0, 24'sd0}},
    // full-range axes cross exactly at the origin
    '{'{16'sh8000, 16'sd0, 16'sh7fff, 16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sh7fff},
      1'b1, '{1'b1, 24'sd0, 24'sd0}},
    // start of A lies inside B: t = 0
    '{'{16'sd0, 16'sd0, 16'sd5, 16'sd5, -16'sd3, 16'sd0, 16'sd3, 16'sd0},
      1'b1, '{1'b1, 24'sd0, 24'sd0}},
    // B line crosses before the start of A (t < 0)
    '{'{16'sd0, 16'sd0, 16'sd10, 16'sd0, -16'sd5, -16'sd5, -16'sd5, 16'sd5},
      1'b1, '{1'b0, 24'sd0, 24'sd0}},
    // non-integer crossings, left to the model
    '{'{16'sd1, 16'sd2, 16'sd7, -16'sd3, -16'sd4, -16'sd5, 16'sd9, 16'sd8},
      1'b0, '{1'b0, 24'sd0, 24'sd0}},
    '{'{16'sd3, 16'sd3, -16'sd5, -16'sd5, 16'sd0, 16'sd0, -16'sd1, 16'sd4},
      1'b0, '{1'b0, 24'sd0, 24'sd0}},
    '{'{16'sd100, -16'sd7, -16'sd33, 16'sd250, -16'sd90, 16'sd60, 16'sd120, -16'sd44},
      1'b0, '{1'b0, 24'sd0, 24'sd0}},
    '{'{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0, 16'sd1, 16'sd1},
      1'b0, '{1'b0, 24'sd0, 24'sd0}}
  };

  // --------------------------------------------------------------------------
  // Random pairs
  // --------------------------------------------------------------------------
  function automatic int rnd(int lo, int hi);
    return lo + int'($urandom_range(hi - lo, 0));
  endfunction

  function automatic pair_t draw_pair();
    int ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    int cx, cy, rad, pick, dx, dy, k, tmp;
    pair_t p;
    pick = $urandom_range(99, 0);
    cx   = rnd(-31000, 31000);
    cy   = rnd(-31000, 31000);
    rad  = 8 << $urandom_range(7, 0);
    // default: all four points in a box, which crosses often
    ax0 = cx + rnd(-rad, rad);  ay0 = cy + rnd(-rad, rad);
    ax1 = cx + rnd(-rad, rad);  ay1 = cy + rnd(-rad, rad);
    bx0 = cx + rnd(-rad, rad);  by0 = cy + rnd(-rad, rad);
    bx1 = cx + rnd(-rad, rad);  by1 = cy + rnd(-rad, rad);
    if (pick < 25) begin
      // anywhere in the field range: mostly misses, toggles every bit
      ax0 = rnd(-32768, 32767);  ay0 = rnd(-32768, 32767);
      ax1 = rnd(-32768, 32767);  ay1 = rnd(-32768, 32767);
      bx0 = rnd(-32768, 32767);  by0 = rnd(-32768, 32767);
      bx1 = rnd(-32768, 32767);  by1 = rnd(-32768, 32767);
    end else if (pick < 60) begin
      // box only
    end else if (pick < 72) begin
      // shared endpoint, either end of A onto either end of B
      if ($urandom_range(1, 0) == 1) begin
        bx0 = ax0;  by0 = ay0;
      end else begin
        bx0 = ax1;  by0 = ay1;
      end
      if ($urandom_range(1, 0) == 1) begin
        tmp = bx0;  bx0 = bx1;  bx1 = tmp;
        tmp = by0;  by0 = by1;  by1 = tmp;
      end
    end else if (pick < 82) begin
      // parallel, sometimes on the same line
      dx  = rnd(-100, 100);
      dy  = rnd(-100, 100);
      k   = rnd(-2, 2);
      ax1 = ax0 + dx;
      ay1 = ay0 + dy;
      if ($urandom_range(1, 0) == 1) begin
        tmp = rnd(-2, 2);
        bx0 = ax0 + tmp * dx;
        by0 = ay0 + tmp * dy;
      end
      bx1 = bx0 + k * dx;
      by1 = by0 + k * dy;
    end else if (pick < 90) begin
      // B shrunk to a point, sometimes sitting on A's start
      if ($urandom_range(1, 0) == 1) begin
        bx0 = ax0;  by0 = ay0;
      end
      bx1 = bx0;  by1 = by0;
    end else begin
      // A horizontal, B vertical: integer crossings and touching ends
      ay1 = ay0;
      bx1 = bx0;
    end
    p.ax0 = coord_t'(ax0);  p.ay0 = coord_t'(ay0);
    p.ax1 = coord_t'(ax1);  p.ay1 = coord_t'(ay1);
    p.bx0 = coord_t'(bx0);  p.by0 = coord_t'(by0);
    p.bx1 = coord_t'(bx1);  p.by1 = coord_t'(by1);
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Handshake driving
  // --------------------------------------------------------------------------
  function automatic void set_phase(hs_phase_e ph);
    case (ph)
      PH_STREAM: begin
        send_idle_pct = 0;   recv_stall_pct = 0;
      end
      PH_SRC_IDLE: begin
        send_idle_pct = 47;  recv_stall_pct = 0;
      end
      PH_SNK_STALL: begin
        send_idle_pct = 0;   recv_stall_pct = 47;
      end
      default: begin
        send_idle_pct = 36;  recv_stall_pct = 36;
      end
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is
  // taken. Valid stays high between back-to-back beats.
  task automatic send_pair(input pair_t p, input bit typed, input crossing_t given);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      pair_valid = 1'b0;
      @(negedge clk);
    end
    cur_pair   = p;
    pair_valid = 1'b1;
    @(posedge clk);
    while (!pair_ready) begin
      @(posedge clk);
    end
    pending_crossings.push_back(typed ? given : predict_crossing(p));
    pairs_sent++;
    @(negedge clk);
  endtask

  // receiver: ready changes on the falling edge only
  always @(negedge clk) begin
    res_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Result checking
  // --------------------------------------------------------------------------
  task automatic flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin : check_results
    crossing_t want;
    if (!rst && res_valid && res_ready) begin
      if (hit) begin
        hits_seen++;
      end else begin
        misses_seen++;
      end
      if (pending_crossings.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing pending: hit %0b x %0d y %0d",
                                hit, cross_x, cross_y));
      end else begin
        want = pending_crossings.pop_front();
        if (hit !== want.hit || cross_x !== want.px || cross_y !== want.py) begin
          flag_mismatch($sformatf(
            "crossing mismatch: hit %0b/%0b x %0d/%0d y %0d/%0d (want/got)",
            want.hit, hit, want.px, cross_x, want.py, cross_y));
        end
      end
    end
  end

  // stall guard: any beat on either channel restarts the count
  always @(posedge clk) begin
    if (rst || (pair_valid && pair_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: timeout, %0d results outstanding", pending_crossings.size());
      $display("tb_top: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int k;
    crossing_t unused;
    unused = '{hit: 1'b0, px: '0, py: '0};
    set_phase(PH_STREAM);
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (k = 0; k < NUM_DIRECTED; k++) begin
      send_pair(dir_rows[k].seg, dir_rows[k].typed, dir_rows[k].want);
    end

    // random part cycles through the four handshake patterns twice
    for (k = 0; k < NUM_RANDOM; k++) begin
      if (k % BLOCK_LEN == 0) begin
        set_phase(hs_phase_e'((k / BLOCK_LEN) % 4));
      end
      send_pair(draw_pair(), 1'b0, unused);
    end
    pair_valid = 1'b0;

    while (pending_crossings.size() != 0) begin
      @(posedge clk);
    end
    // catch any stray beat after the last expected one
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("tb_top: %0d segment pairs (%0d hits, %0d misses) under four handshake patterns",
             pairs_sent, hits_seen, misses_seen);
    $display("tb_top: %0d mismatching or unexpected result beats", mismatches);
    if (mismatches == 0 && pending_crossings.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/segint_pkg.sv
sv/segint_front.sv
sv/segint_cell.sv
sv/segint_out.sv
sv/segment_intersection.sv
dv/tb_top.sv
